// ===== hdl/rwu_pkg.sv =====
// Shared types and constants for the RMSProp weight update block.
// No dependencies.
package rwu_pkg;

  typedef struct packed {
    logic [15:0]        element_index;
    logic signed [31:0] gradient;
    logic signed [31:0] weight_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        result_index;
    logic signed [31:0] weight_out;
    logic               clipped;
  } out_item_t;

  localparam int MeanW = 48;
  localparam int RootW = 40;   // floor(sqrt(2^64)) fits 33 bits; margin kept
  localparam int NumW  = 57;
  localparam int DenW  = 41;

  localparam logic [1:0] RegLr    = 2'd0;
  localparam logic [1:0] RegDecay = 2'd1;
  localparam logic [1:0] RegEps   = 2'd2;

  localparam logic [24:0] LrReset    = 25'd167772;
  localparam logic [15:0] DecayReset = 16'd64881;
  localparam logic [23:0] EpsReset   = 24'd1;

endpackage

// ===== hdl/rwu_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module rwu_ram #(
  parameter int Width = 48,
  parameter int Depth = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/rwu_sqrt.sv =====
// Pipelined integer square root, two result bits per stage, 64-bit radicand.
// Depends on rwu_pkg. A shift register with a side tag, held while en is low.
module rwu_sqrt #(
  parameter int TagW = 8
) (
  input  logic            clk,
  input  logic            en,
  input  logic [63:0]     rad,
  input  logic [TagW-1:0] tag_in,
  output logic [31:0]     root,
  output logic [TagW-1:0] tag_out
);
  import rwu_pkg::*;
  localparam int Stages = 16;

  logic [63:0]     rem_r [Stages+1];
  logic [63:0]     x_r   [Stages+1];
  logic [31:0]     res_r [Stages+1];
  logic [TagW-1:0] tag_r [Stages+1];

  always_comb begin
    rem_r[0] = 64'd0;
    x_r[0]   = rad;
    res_r[0] = 32'd0;
    tag_r[0] = tag_in;
  end

  // each stage: two restoring steps
  for (genvar s = 0; s < Stages; s++) begin : g_st
    logic [63:0] r1, r2, t1, t2;
    logic [31:0] q1, q2;
    always_comb begin
      r1 = {rem_r[s][61:0], x_r[s][63:62]};
      t1 = {res_r[s][29:0], 2'b01};
      if (r1 >= t1) begin
        r1 = r1 - t1; q1 = {res_r[s][30:0], 1'b1};
      end else q1 = {res_r[s][30:0], 1'b0};
      r2 = {r1[61:0], x_r[s][61:60]};
      t2 = {q1[29:0], 2'b01};
      if (r2 >= t2) begin
        r2 = r2 - t2; q2 = {q1[30:0], 1'b1};
      end else q2 = {q1[30:0], 1'b0};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= r2;
        x_r[s+1]   <= {x_r[s][59:0], 4'd0};
        res_r[s+1] <= q2;
        tag_r[s+1] <= tag_r[s];
      end
    end
  end

  assign root    = res_r[Stages];
  assign tag_out = tag_r[Stages];
endmodule

// ===== hdl/rwu_div.sv =====
// Pipelined restoring divider, one quotient bit per stage: q = n / d.
// Depends on rwu_pkg. Numerator 57 bits, divisor 41 bits.
module rwu_div #(
  parameter int TagW = 8
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [rwu_pkg::NumW-1:0] num,
  input  logic [rwu_pkg::DenW-1:0] den,
  input  logic [TagW-1:0]         tag_in,
  output logic [rwu_pkg::NumW-1:0] quo,
  output logic [TagW-1:0]         tag_out
);
  import rwu_pkg::*;

  logic [NumW-1:0] n_r [NumW+1];
  logic [DenW-1:0] d_r [NumW+1];
  logic [DenW:0]   r_r [NumW+1];
  logic [TagW-1:0] t_r [NumW+1];

  always_comb begin
    n_r[0] = num; d_r[0] = den; r_r[0] = '0; t_r[0] = tag_in;
  end

  for (genvar s = 0; s < NumW; s++) begin : g_st
    logic [DenW+1:0] sh, df;
    always_comb begin
      sh = {r_r[s], n_r[s][NumW-1]};
      df = sh - {1'b0, 1'b0, d_r[s]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!df[DenW+1]) begin
          r_r[s+1] <= df[DenW:0];
          n_r[s+1] <= {n_r[s][NumW-2:0], 1'b1};
        end else begin
          r_r[s+1] <= sh[DenW:0];
          n_r[s+1] <= {n_r[s][NumW-2:0], 1'b0};
        end
        d_r[s+1] <= d_r[s];
        t_r[s+1] <= t_r[s];
      end
    end
  end

  assign quo     = n_r[NumW];
  assign tag_out = t_r[NumW];
endmodule

// ===== hdl/rmsprop_weight_update_top.sv =====
// RMSProp weight update, one element per cycle while the output is not held
// and no clearing pass runs. A registered mean-cache read, read-modify-write
// with forwarding from the item one stage ahead, then a 16-stage square root
// and a 57-stage divider. After reset the cache is cleared by a pass over
// all ELEMENT_DEPTH entries, one entry a cycle, during which no item is
// accepted. The whole pipeline advances only when the output register is
// free or being taken.
// Depends on rwu_pkg, rwu_ram, rwu_sqrt, rwu_div.
module rmsprop_weight_update_top #(
  parameter int ELEMENT_DEPTH = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rwu_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rwu_pkg::out_item_t  out_item,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import rwu_pkg::*;
  localparam int AW = (ELEMENT_DEPTH > 1) ? $clog2(ELEMENT_DEPTH) : 1;

  // configuration registers
  logic [24:0] lr_r;
  logic [15:0] decay_r;
  logic [23:0] eps_r;
  logic        cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= LrReset; decay_r <= DecayReset; eps_r <= EpsReset;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        RegLr:    lr_r    <= cfg_pwdata[24:0];
        RegDecay: decay_r <= cfg_pwdata[15:0];
        RegEps:   eps_r   <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (cfg_paddr[3:2])
      RegLr:    cfg_prdata = {7'd0, lr_r};
      RegDecay: cfg_prdata = {16'd0, decay_r};
      RegEps:   cfg_prdata = {8'd0, eps_r};
      default:  cfg_prdata = 32'd0;
    endcase
  end

  // clearing pass
  logic          clr_r;
  logic [AW:0]   clr_cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= 1'b1; clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == (AW+1)'(ELEMENT_DEPTH - 1)) clr_r <= 1'b0;
    end
  end

  // global advance
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en && !clr_r;

  // stage 1: memory read, gradient magnitude and square
  logic          s1_v_r;
  in_item_t      s1_r;
  logic          s1_inr_r;
  logic [31:0]   s1_mag_r;
  logic [46:0]   s1_gsq_r;
  logic [31:0]   in_mag;
  logic          acc_in;
  assign acc_in = in_valid && in_ready;
  assign in_mag = in_item.gradient[31] ? 32'(-in_item.gradient) : in_item.gradient;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= acc_in;
    if (en) begin
      s1_r     <= in_item;
      s1_inr_r <= ({16'd0, in_item.element_index} < 32'(ELEMENT_DEPTH));
      s1_mag_r <= in_mag;
      s1_gsq_r <= 47'((64'(in_mag) * 64'(in_mag) + 64'h8000) >> 16);
    end
  end

  logic [MeanW-1:0] rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [MeanW-1:0] wr_data;
  logic [MeanW-1:0] s2_mean_r;
  logic [AW-1:0]    s2_addr_r;
  logic             s2_w_r;

  rwu_ram #(.Width(MeanW), .Depth(ELEMENT_DEPTH)) u_mean (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
    .raddr(en ? in_item.element_index[AW-1:0] : s1_r.element_index[AW-1:0]),
    .rdata(rd_data)
  );

  // stage 1 compute: forward from the write of the previous item
  logic [MeanW-1:0] old;
  logic [64+16:0]   acc;
  logic [65:0]      mean_w;
  logic [MeanW-1:0] mean_s;
  logic             mclip;
  always_comb begin
    if (!s1_inr_r) old = '0;
    else if (s2_w_r && s2_addr_r == s1_r.element_index[AW-1:0]) old = s2_mean_r;
    else old = rd_data;
    acc = 81'(decay_r) * 81'(old) + 81'(17'h10000 - 17'(decay_r)) * 81'(s1_gsq_r);
    mean_w = 66'(acc >> 16) + 66'(acc[15]);
    mclip = mean_w > 66'h0FFFFFFFFFFFF;
    mean_s = mclip ? {MeanW{1'b1}} : mean_w[MeanW-1:0];
  end

  assign wr_en   = clr_r || (s1_v_r && en && s1_inr_r);
  assign wr_addr = clr_r ? clr_cnt_r[AW-1:0] : s1_r.element_index[AW-1:0];
  assign wr_data = clr_r ? '0 : mean_s;

  // stage 2 register: mean for sqrt, also forwarding source
  logic        s2_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0; s2_w_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
      s2_w_r <= s1_v_r && s1_inr_r;
    end
    if (en) begin
      s2_mean_r <= mean_s;
      s2_addr_r <= s1_r.element_index[AW-1:0];
    end
  end

  // side data carried along the pipeline
  localparam int TagW = 1 + 16 + 32 + 32 + 1;
  logic            s2_sign_r, s2_clip_r;
  logic [15:0]     s2_idx_r;
  logic [31:0]     s2_w_val_r, s2_mag_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_sign_r  <= s1_r.gradient[31];
      s2_clip_r  <= mclip;
      s2_idx_r   <= s1_r.element_index;
      s2_w_val_r <= s1_r.weight_in;
      s2_mag_r   <= s1_mag_r;
    end
  end

  logic [31:0]     root;
  logic [TagW-1:0] sq_tag;
  logic [TagW-1:0] s2_tag;
  assign s2_tag = {s2_v_r, s2_idx_r, s2_w_val_r, s2_mag_r, s2_sign_r};
  // clip bit travels in a separate small shift register aligned with sqrt
  logic            clip_sq_r [17];
  assign clip_sq_r[0] = s2_clip_r;
  for (genvar k = 0; k < 16; k++) begin : g_cs
    always_ff @(posedge clk) if (en) clip_sq_r[k+1] <= clip_sq_r[k];
  end

  rwu_sqrt #(.TagW(TagW)) u_sqrt (
    .clk(clk), .en(en), .rad({s2_mean_r, 16'd0}), .tag_in(s2_tag),
    .root(root), .tag_out(sq_tag)
  );

  // numerator and denominator
  logic [NumW-1:0] num;
  logic [DenW-1:0] den;
  assign num = NumW'(lr_r) * NumW'(sq_tag[32:1]);
  assign den = DenW'(root) + DenW'(eps_r == 24'd0 ? 24'd1 : eps_r);

  logic [NumW-1:0] num_r;
  logic [DenW-1:0] den_r;
  logic [TagW:0]   d_tag_r;
  always_ff @(posedge clk) begin
    if (en) begin
      num_r   <= num + NumW'(den >> 1);
      den_r   <= den;
      d_tag_r <= {clip_sq_r[16], sq_tag};
    end
  end

  logic [NumW-1:0] quo;
  logic [TagW:0]   dv_tag;
  rwu_div #(.TagW(TagW+1)) u_div (
    .clk(clk), .en(en), .num(num_r), .den(den_r), .tag_in(d_tag_r),
    .quo(quo), .tag_out(dv_tag)
  );

  // final subtract (add for a negative gradient) and saturate into output register
  logic signed [NumW+1:0] res;
  logic                   sclip;
  logic signed [31:0]     wsat;
  always_comb begin
    if (dv_tag[0])
      res = (NumW+2)'(signed'(dv_tag[64:33])) + signed'({2'b00, quo});
    else
      res = (NumW+2)'(signed'(dv_tag[64:33])) - signed'({2'b00, quo});
    sclip = (res > (NumW+2)'(64'sh7FFFFFFF)) || (res < -(NumW+2)'(64'sh80000000));
    if (res > (NumW+2)'(64'sh7FFFFFFF)) wsat = 32'sh7FFFFFFF;
    else if (res < -(NumW+2)'(64'sh80000000)) wsat = 32'sh80000000;
    else wsat = res[31:0];
  end

  // bit TagW carries the mean clip, bit TagW-1 the valid
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= dv_tag[TagW-1];
    if (en) begin
      out_item.result_index <= dv_tag[80:65];
      out_item.weight_out   <= wsat;
      out_item.clipped      <= sclip || dv_tag[TagW];
    end
  end

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item));
  // nothing taken while the cache is being cleared
  a_no_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !in_ready);
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready);
  a_valid_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(out_valid));
endmodule
